// ===== design/hq_pkg.sv =====
`default_nettype none

package hq_pkg;

    // Store geometry and queue depths
    localparam int MAX_SIDE_DEF = 256;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;

    // Fixed-point constants
    localparam logic [31:0] MISS_HEIGHT = 32'hFFFF_0000;   // -1.0 in Q16.16
    localparam logic [31:0] SAT_HIGH    = 32'h7FFF_FFFF;
    localparam logic [16:0] FRAC_ONE    = 17'h1_0000;      // 1.0 in 1.16

    // Register reset values
    localparam logic [8:0]  SIDE_RESET = 9'd256;
    localparam logic [31:0] CPU_RESET  = 32'h0001_0000;
    localparam logic [31:0] GAIN_RESET = 32'd257;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_X = 3'd0,
        REG_SIDE_Z = 3'd1,
        REG_ORG_X  = 3'd2,
        REG_ORG_Z  = 3'd3,
        REG_CPU_X  = 3'd4,
        REG_CPU_Z  = 3'd5,
        REG_GAIN   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic               mode;
        logic [7:0]         sample_x_index;
        logic [7:0]         sample_z_index;
        logic [7:0]         height_byte;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] height;
    } out_word_t;

    typedef struct packed {
        logic [8:0]         grid_side_x;
        logic [8:0]         grid_side_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_z;
        logic [31:0]        cells_per_unit_x;
        logic [31:0]        cells_per_unit_z;
        logic [31:0]        height_gain;
    } cfg_t;

    // Classified word between the front stage and the back pipeline
    typedef struct packed {
        logic        is_query;
        logic        neg_x;      // position left of the origin along X
        logic        neg_z;
        logic [31:0] t_x;        // pos - origin, zero when negative
        logic [31:0] t_z;
        logic [7:0]  ld_x;
        logic [7:0]  ld_z;
        logic [7:0]  ld_byte;
    } mid_word_t;

endpackage

`default_nettype wire

// ===== design/hq_fifo.sv =====
`default_nettype none

module hq_fifo
    import hq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/hq_front.sv =====
`default_nettype none

module hq_front
    import hq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_z,
    input  wire logic               push,
    output logic                    full,
    input  wire in_word_t           item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mid_word_t               out_word
);

    logic        valid_reg, valid_next;
    mid_word_t   word_reg, word_next;
    logic        take, move;
    logic [32:0] tx, tz;

    assign move      = valid_reg && out_ready;
    assign full      = valid_reg && !out_ready;
    assign take      = push && !full;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // Translate to grid space; a negative offset only matters through its sign
    always_comb
    begin
        tx = {item.pos_x[31], item.pos_x} - {origin_x[31], origin_x};
        tz = {item.pos_z[31], item.pos_z} - {origin_z[31], origin_z};
        word_next.is_query = item.mode;
        word_next.neg_x    = tx[32];
        word_next.neg_z    = tz[32];
        word_next.t_x      = tx[32] ? '0 : tx[31:0];
        word_next.t_z      = tz[32] ? '0 : tz[31:0];
        word_next.ld_x     = item.sample_x_index;
        word_next.ld_z     = item.sample_z_index;
        word_next.ld_byte  = item.height_byte;
        valid_next         = take || (valid_reg && !move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/hq_back.sv =====
`default_nettype none

module hq_back
    import hq_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      in_valid,
    input  wire mid_word_t in_word,
    output logic           in_pop,
    output logic           empty,
    input  wire logic      pop,
    output out_word_t      result
);

    localparam int COORD_W    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 2;
    localparam int HALF_W     = COORD_W - 1;
    localparam int BANK_AW    = 2 * HALF_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int SIDE_W     = ($clog2(MAX_SIDE + 1) > 9) ? $clog2(MAX_SIDE + 1) : 9;
    localparam int CRED_W     = $clog2(OUT_DEPTH + 1);

    // Credits: queries issued but not yet popped
    logic [CRED_W-1:0] pending_reg, pending_next;
    logic              issue_query, out_pop;

    // Stage A: issued word
    logic      a_valid_reg;
    mid_word_t a_word_reg;
    logic [63:0] gx, gz;

    // Stage B: cell and fraction
    logic        b_valid_reg, b_query_reg;
    logic [31:0] b_cell_x_reg, b_cell_z_reg;
    logic [15:0] b_frac_x_reg, b_frac_z_reg;
    logic        b_negmiss_x_reg, b_negmiss_z_reg;
    logic [7:0]  b_ld_x_reg, b_ld_z_reg, b_ld_byte_reg;

    logic [SIDE_W-1:0]  eff_x, eff_z;
    logic               ok_x, ok_z, b_hit;
    logic [COORD_W-1:0] cx, cz, wx, wz;
    logic [COORD_W-1:0] xsel [2];
    logic [COORD_W-1:0] zsel [2];
    logic [BANK_AW-1:0] rd_addr [4];
    logic [BANK_AW-1:0] wr_addr;
    logic [1:0]         wr_bank;
    logic               wr_en;
    logic [7:0]         bank_q [4];

    // Stage C: corner heights arrive
    logic        c_valid_reg, c_hit_reg, c_px_reg, c_pz_reg;
    logic [15:0] c_frac_x_reg, c_frac_z_reg;
    logic [7:0]  h00, h10, h01, h11, base;
    logic [16:0] wa, wb;
    logic signed [8:0]  da, db;
    logic signed [26:0] p1, p2;
    logic signed [27:0] isum;
    logic               lower;

    // Stage D and E
    logic        d_valid_reg, d_hit_reg;
    logic [23:0] d_interp_reg;
    logic [55:0] prod;
    logic        e_valid_reg, e_hit_reg;
    logic [55:0] e_prod_reg;
    out_word_t   e_word;

    logic [$bits(out_word_t)-1:0] out_q;

    // Issue a load at any time; issue a query only with room reserved downstream
    assign in_pop      = in_valid && (!in_word.is_query || (pending_reg < CRED_W'(OUT_DEPTH)));
    assign issue_query = in_pop && in_word.is_query;
    assign out_pop     = pop && !empty;
    assign pending_next = pending_reg + CRED_W'(issue_query) - CRED_W'(out_pop);

    // Grid scaling, Q16.16 times Q16.16
    assign gx = 64'(a_word_reg.t_x) * 64'(cfg.cells_per_unit_x);
    assign gz = 64'(a_word_reg.t_z) * 64'(cfg.cells_per_unit_z);

    // Bound check and bank addressing
    always_comb
    begin
        eff_x = (SIDE_W'(cfg.grid_side_x) > SIDE_W'(MAX_SIDE)) ?
                SIDE_W'(MAX_SIDE) : SIDE_W'(cfg.grid_side_x);
        eff_z = (SIDE_W'(cfg.grid_side_z) > SIDE_W'(MAX_SIDE)) ?
                SIDE_W'(MAX_SIDE) : SIDE_W'(cfg.grid_side_z);
        ok_x  = (eff_x >= SIDE_W'(2)) && !b_negmiss_x_reg &&
                (b_cell_x_reg < 32'(eff_x - SIDE_W'(1)));
        ok_z  = (eff_z >= SIDE_W'(2)) && !b_negmiss_z_reg &&
                (b_cell_z_reg < 32'(eff_z - SIDE_W'(1)));
        b_hit = ok_x && ok_z;

        // The four corners fall one into each parity bank
        cx = COORD_W'(b_cell_x_reg);
        cz = COORD_W'(b_cell_z_reg);
        for (int p = 0; p < 2; p++)
        begin
            xsel[p] = (cx[0] == 1'(p)) ? cx : cx + 1'b1;
            zsel[p] = (cz[0] == 1'(p)) ? cz : cz + 1'b1;
        end
        for (int b = 0; b < 4; b++)
        begin
            rd_addr[b] = {xsel[b / 2][COORD_W-1:1], zsel[b % 2][COORD_W-1:1]};
        end

        wx      = COORD_W'(b_ld_x_reg);
        wz      = COORD_W'(b_ld_z_reg);
        wr_en   = b_valid_reg && !b_query_reg &&
                  (32'(b_ld_x_reg) < 32'(MAX_SIDE)) && (32'(b_ld_z_reg) < 32'(MAX_SIDE));
        wr_bank = {wx[0], wz[0]};
        wr_addr = {wx[COORD_W-1:1], wz[COORD_W-1:1]};
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= b_ld_byte_reg;
            end
            bank_q[b] <= mem[rd_addr[b]];
        end
    end

    // Barycentric blend over the lower or upper triangle
    always_comb
    begin
        h00   = bank_q[{c_px_reg, c_pz_reg}];
        h10   = bank_q[{~c_px_reg, c_pz_reg}];
        h01   = bank_q[{c_px_reg, ~c_pz_reg}];
        h11   = bank_q[{~c_px_reg, ~c_pz_reg}];
        lower = ({1'b0, c_frac_x_reg} + {1'b0, c_frac_z_reg}) <= FRAC_ONE;
        if (lower)
        begin
            base = h00;
            wa   = {1'b0, c_frac_x_reg};
            wb   = {1'b0, c_frac_z_reg};
        end
        else
        begin
            base = h11;
            wa   = FRAC_ONE - {1'b0, c_frac_z_reg};
            wb   = FRAC_ONE - {1'b0, c_frac_x_reg};
        end
        da   = $signed({1'b0, h10}) - $signed({1'b0, base});
        db   = $signed({1'b0, h01}) - $signed({1'b0, base});
        p1   = $signed({1'b0, wa}) * da;
        p2   = $signed({1'b0, wb}) * db;
        isum = $signed({4'b0, base, 16'b0}) + 28'(p1) + 28'(p2);
    end

    assign prod = 56'(d_interp_reg) * 56'(cfg.height_gain);

    // Saturate the scaled height, substitute -1.0 on a miss
    always_comb
    begin
        e_word.hit = e_hit_reg;
        if (!e_hit_reg)
        begin
            e_word.height = MISS_HEIGHT;
        end
        else if (|e_prod_reg[55:47])
        begin
            e_word.height = SAT_HIGH;
        end
        else
        begin
            e_word.height = e_prod_reg[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            a_valid_reg <= in_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_query_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            a_word_reg <= in_word;
        end
        b_query_reg     <= a_word_reg.is_query;
        b_cell_x_reg    <= gx[63:32];
        b_cell_z_reg    <= gz[63:32];
        b_frac_x_reg    <= gx[31:16];
        b_frac_z_reg    <= gz[31:16];
        b_negmiss_x_reg <= a_word_reg.neg_x && (cfg.cells_per_unit_x != '0);
        b_negmiss_z_reg <= a_word_reg.neg_z && (cfg.cells_per_unit_z != '0);
        b_ld_x_reg      <= a_word_reg.ld_x;
        b_ld_z_reg      <= a_word_reg.ld_z;
        b_ld_byte_reg   <= a_word_reg.ld_byte;

        c_hit_reg       <= b_hit;
        c_frac_x_reg    <= b_frac_x_reg;
        c_frac_z_reg    <= b_frac_z_reg;
        c_px_reg        <= cx[0];
        c_pz_reg        <= cz[0];

        d_hit_reg       <= c_hit_reg;
        d_interp_reg    <= isum[27] ? '0 : isum[23:0];

        e_hit_reg       <= d_hit_reg;
        e_prod_reg      <= prod;
    end

    hq_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (e_valid_reg),
        .wr_data (e_word),
        .full    (),
        .rd_en   (pop),
        .rd_data (out_q),
        .empty   (empty)
    );

    assign result = out_q;

endmodule

`default_nettype wire

// ===== design/heightmap_height_query.sv =====
`default_nettype none

// Terrain height lookup. Push load words (mode 0) to fill the height store one
// byte at a time and query words (mode 1) to get one result each: hit and a
// signed Q16.16 height, or hit low with -1.0 when the position falls outside
// the grid. Loads and queries are carried out strictly in push order, so a
// query sees every load pushed ahead of it; loads produce no result. The store
// holds MAX_SIDE x MAX_SIDE bytes split into four banks by the parity of the
// column and row, so all four cell corners are read in the same cycle. Its
// contents are undefined after reset: load every sample a query can touch
// before querying it; no clearing pass runs. The block takes one word per
// clock unless a query is held for want of a result slot. A query passes
// the front stage, a four-entry queue and five back stages (scale, bank
// read, blend, gain, saturate), then an eight-entry result queue, to reach
// the result ports. Queries stall only while the result queue has no free
// slot reserved for them. Write configuration only while no word is in
// flight.
module heightmap_height_query
    import hq_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_word_t             item,
    output logic                      empty,
    input  wire logic                 pop,
    output out_word_t                 result,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cfg_t      cfg_reg;
    logic      mid_push, mid_full, mid_pop, mid_empty;
    mid_word_t front_word;
    logic [$bits(mid_word_t)-1:0] mid_q;

    // Hold configuration; ignore writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_side_x      <= SIDE_RESET;
            cfg_reg.grid_side_z      <= SIDE_RESET;
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_z         <= '0;
            cfg_reg.cells_per_unit_x <= CPU_RESET;
            cfg_reg.cells_per_unit_z <= CPU_RESET;
            cfg_reg.height_gain      <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SIDE_X: cfg_reg.grid_side_x      <= cfg_data[8:0];
                REG_SIDE_Z: cfg_reg.grid_side_z      <= cfg_data[8:0];
                REG_ORG_X:  cfg_reg.origin_x         <= cfg_data;
                REG_ORG_Z:  cfg_reg.origin_z         <= cfg_data;
                REG_CPU_X:  cfg_reg.cells_per_unit_x <= cfg_data;
                REG_CPU_Z:  cfg_reg.cells_per_unit_z <= cfg_data;
                REG_GAIN:   cfg_reg.height_gain      <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Front: accept and classify, translate by the origin
    hq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin_x  (cfg_reg.origin_x),
        .origin_z  (cfg_reg.origin_z),
        .push      (push),
        .full      (full),
        .item      (item),
        .out_valid (mid_push),
        .out_ready (!mid_full),
        .out_word  (front_word)
    );

    // Decoupling queue between front and back
    hq_fifo #(
        .WIDTH ($bits(mid_word_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_word),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_q),
        .empty   (mid_empty)
    );

    // Back: scale, store access, blend, gain and result queue
    hq_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (!mid_empty),
        .in_word  (mid_q),
        .in_pop   (mid_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

`ifndef SYNTH
    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_push && mid_full) |-> full)
        else $error("front open for a new word while its queue is full");

    a_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("back issued from an empty queue");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.hit) |-> (result.height == MISS_HEIGHT))
        else $error("miss result without -1.0 height");

    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.hit) |-> !result.height[31])
        else $error("hit result with negative height");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_heightmap_height_query.sv =====
module tb_heightmap_height_query;
    import hq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Word modes of the input queue
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register index past the end of the map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int DRAIN_CYCLES   = 24;    // covers the push-to-result latency
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int SHOWN_FAILS    = 10;

    // Result-side stall patterns
    typedef enum int {
        POP_STREAM,
        POP_COIN,
        POP_SPARSE,
        POP_HOLD
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    in_word_t             item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    out_word_t            result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Predictor state: configuration, height samples, and which samples the
    // stimulus has already scheduled a load for
    cfg_t      terrain_cfg;
    logic [7:0] heights [0:65535];
    bit         written [0:65535];
    out_word_t  height_queue [$];

    int          words_sent = 0;
    int          burst_left = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    stall_mode_t pop_mode = POP_STREAM;
    int          pop_left = 0;

    heightmap_height_query dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Map one world coordinate to a grid cell and a 16-bit fraction.
    // Return 0 when the coordinate falls outside the usable cells.
    function automatic bit map_axis(input logic [31:0] pos, input logic [31:0] origin,
                                    input logic [31:0] factor, input logic [8:0] side,
                                    output logic [7:0] cell_idx, output logic [15:0] frac);
        longint          offset;
        longint unsigned grid;
        int              eff;
        cell_idx = '0;
        frac = '0;
        eff = (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side);
        offset = longint'($signed(pos)) - longint'($signed(origin));
        if (eff < 2)
            return 1'b0;
        // Left of the origin: a miss, unless the factor collapses the axis to zero
        if (offset < 0)
        begin
            if (factor != 0)
                return 1'b0;
            offset = 0;
        end
        grid = offset;
        grid = grid * factor;
        if (grid[63:32] >= eff - 1)
            return 1'b0;
        cell_idx = grid[39:32];
        frac = grid[31:16];
        return 1'b1;
    endfunction

    // Work out the result word of one query against the current store.
    function automatic out_word_t predict_height(input logic [31:0] px, input logic [31:0] pz);
        out_word_t    r;
        logic [7:0]   cx, cz;
        logic [15:0]  fx, fz;
        longint       h00, h10, h01, h11, blend, fxl, fzl;
        logic [63:0]  scaled;
        r.hit = 1'b0;
        r.height = MISS_HEIGHT;
        if (map_axis(px, terrain_cfg.origin_x, terrain_cfg.cells_per_unit_x,
                     terrain_cfg.grid_side_x, cx, fx) &&
            map_axis(pz, terrain_cfg.origin_z, terrain_cfg.cells_per_unit_z,
                     terrain_cfg.grid_side_z, cz, fz))
        begin
            h00 = heights[{cx, cz}];
            h10 = heights[{cx + 8'd1, cz}];
            h01 = heights[{cx, cz + 8'd1}];
            h11 = heights[{cx + 8'd1, cz + 8'd1}];
            fxl = fx;
            fzl = fz;
            // Lower triangle includes the diagonal itself
            if (fxl + fzl <= 65536)
                blend = h00 * 65536 + fxl * (h10 - h00) + fzl * (h01 - h00);
            else
                blend = h11 * 65536 + (65536 - fzl) * (h10 - h11)
                      + (65536 - fxl) * (h01 - h11);
            if (blend < 0)
                blend = 0;
            scaled = unsigned'(blend) * 64'(terrain_cfg.height_gain);
            scaled = scaled >> 16;
            if (scaled > 64'(SAT_HIGH))
                scaled = 64'(SAT_HIGH);
            r.hit = 1'b1;
            r.height = scaled[31:0];
        end
        return r;
    endfunction

    // Compare one popped result word with the oldest prediction.
    function automatic void check_result(input out_word_t got);
        out_word_t want;
        if (height_queue.size() == 0)
        begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
                $display("result word with nothing pending: hit=%0b height=%h",
                         got.hit, got.height);
            return;
        end
        want = height_queue.pop_front();
        if (got.hit !== want.hit || got.height !== want.height)
        begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
                $display("height mismatch: expected hit=%0b height=%h, got hit=%0b height=%h",
                         want.hit, want.height, got.hit, got.height);
        end
    endfunction

    // Advance the predictor on one accepted input word.
    function automatic void apply_word(input in_word_t w);
        if (w.mode == MODE_LOAD)
            heights[{w.sample_x_index, w.sample_z_index}] = w.height_byte;
        else
            height_queue.insert(height_queue.size(), predict_height(w.pos_x, w.pos_z));
    endfunction

    // Check results before taking new predictions, all in one process, so the
    // queue never sees both sides of a clock edge in an undefined order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                apply_word(item);
        end
    end

    // Drive pop on a pattern of its own: full streaming, coin flips, sparse
    // pops and solid stalls, each for a random stretch.
    always @(negedge clk)
    begin
        if (pop_left == 0)
        begin
            pop_mode = stall_mode_t'($urandom_range(0, 3));
            pop_left = (pop_mode == POP_HOLD) ? $urandom_range(5, 40) : $urandom_range(10, 150);
        end
        pop_left--;
        case (pop_mode)
            POP_STREAM: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
            default:    pop <= 1'b0;
        endcase
    end

    // End the run when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Random filler for fields a word's mode does not use.
    function automatic in_word_t noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_word_t)-1:0];
    endfunction

    // Push one word: open a new burst with a random gap when the old one runs
    // out, then hold the word until the block takes it.
    task automatic push_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk) push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full !== 1'b0);
        words_sent++;
    endtask

    task automatic load_sample(input logic [7:0] x, input logic [7:0] z, input logic [7:0] b);
        in_word_t w;
        w = noise_word();
        w.mode = MODE_LOAD;
        w.sample_x_index = x;
        w.sample_z_index = z;
        w.height_byte = b;
        written[{x, z}] = 1'b1;
        push_word(w);
    endtask

    // Query a position; load any corner of the target cell that was never
    // written first, so no query reads an undefined sample.
    task automatic query_at(input logic [31:0] px, input logic [31:0] pz);
        in_word_t    w;
        logic [7:0]  cx, cz;
        logic [15:0] fx, fz;
        int          dx, dz;
        if (map_axis(px, terrain_cfg.origin_x, terrain_cfg.cells_per_unit_x,
                     terrain_cfg.grid_side_x, cx, fx) &&
            map_axis(pz, terrain_cfg.origin_z, terrain_cfg.cells_per_unit_z,
                     terrain_cfg.grid_side_z, cz, fz))
        begin
            for (dx = 0; dx < 2; dx++)
                for (dz = 0; dz < 2; dz++)
                    if (!written[{8'(cx + dx), 8'(cz + dz)}])
                        load_sample(8'(cx + dx), 8'(cz + dz), 8'($urandom_range(0, 255)));
        end
        w = noise_word();
        w.mode = MODE_QUERY;
        w.pos_x = px;
        w.pos_z = pz;
        push_word(w);
    endtask

    // Pick a coordinate along one axis: mostly inside the usable cells, some
    // just past the far bound, some left of the origin, some anywhere.
    function automatic logic [31:0] pick_pos(input logic [31:0] origin,
                                             input logic [31:0] factor,
                                             input logic [8:0] side);
        longint unsigned span, t;
        logic [63:0]     raw;
        int              eff, r;
        eff = (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side);
        if (factor == 0 || eff < 2)
            span = 64'h1_0000_0000;
        else
            span = {32'(eff - 1), 32'h0} / factor;
        if (span > 64'h1_0000_0000)
            span = 64'h1_0000_0000;
        raw = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 75)
            t = raw % (span + 1);
        else if (r < 85)
            t = span + $urandom_range(0, 300);
        else if (r < 92)
            return origin - $urandom_range(1, 300);
        else
            return $urandom;
        return origin + t[31:0];
    endfunction

    task automatic run_random(input int count);
        int first;
        first = words_sent;
        while (words_sent - first < count)
        begin
            if ($urandom_range(0, 99) < 20)
                load_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            else
                query_at(pick_pos(terrain_cfg.origin_x, terrain_cfg.cells_per_unit_x,
                                  terrain_cfg.grid_side_x),
                         pick_pos(terrain_cfg.origin_z, terrain_cfg.cells_per_unit_z,
                                  terrain_cfg.grid_side_z));
        end
    endtask

    // Drop push, wait for every predicted result, then let trailing loads
    // drain through the pipeline.
    task automatic settle();
        @(negedge clk) push <= 1'b0;
        burst_left = 0;
        while (height_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; hold cfg_write high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_SIDE_X: terrain_cfg.grid_side_x = data[8:0];
            REG_SIDE_Z: terrain_cfg.grid_side_z = data[8:0];
            REG_ORG_X:  terrain_cfg.origin_x = data;
            REG_ORG_Z:  terrain_cfg.origin_z = data;
            REG_CPU_X:  terrain_cfg.cells_per_unit_x = data;
            REG_CPU_Z:  terrain_cfg.cells_per_unit_z = data;
            REG_GAIN:   terrain_cfg.height_gain = data;
            default:    ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    // Reset configuration: one world unit per cell, so Q16.16 positions read
    // directly as cell and fraction. Cover both triangles, the diagonal, the
    // last usable cell, misses past both far bounds and left of the origin on X.
    task automatic test_directed_defaults();
        load_sample(8'd0, 8'd0, 8'd255);
        load_sample(8'd1, 8'd0, 8'd0);
        load_sample(8'd0, 8'd1, 8'd128);
        load_sample(8'd1, 8'd1, 8'd1);
        load_sample(8'd254, 8'd254, 8'd0);
        load_sample(8'd255, 8'd254, 8'd17);
        load_sample(8'd254, 8'd255, 8'd200);
        load_sample(8'd255, 8'd255, 8'd255);
        query_at(32'h0000_0000, 32'h0000_0000);   // exact corner
        query_at(32'h0000_4000, 32'h0000_4000);   // lower triangle
        query_at(32'h0000_C000, 32'h0000_C000);   // upper triangle
        query_at(32'h0000_8000, 32'h0000_8000);   // on the diagonal
        query_at(32'h0000_8001, 32'h0000_8000);   // just past the diagonal
        query_at(32'h0000_FFFF, 32'h0000_0000);   // largest fraction along X
        query_at(32'h00FE_FFFF, 32'h00FE_FFFF);   // far corner of the last cell
        query_at(32'h00FF_0000, 32'h0000_0000);   // cell bound along X
        query_at(32'h0000_0000, 32'h00FF_0000);   // cell bound along Z
        query_at(32'hFFFF_0000, 32'h0000_0000);   // left of the origin
        query_at(32'h8000_0000, 32'h7FFF_FFFF);   // position extremes
        query_at(32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_random_defaults();
        run_random(200);
    endtask

    // Small grids, negative origin, fractional and steep factors, zero gain.
    task automatic test_small_grid();
        settle();
        write_reg(REG_SIDE_X, 32'd2);
        write_reg(REG_SIDE_Z, 32'd3);
        write_reg(REG_ORG_X, 32'hFFFB_0000);
        write_reg(REG_ORG_Z, 32'h0000_1234);
        write_reg(REG_CPU_X, 32'h0000_8000);
        write_reg(REG_CPU_Z, 32'h0003_0000);
        write_reg(REG_GAIN, 32'h0000_0000);
        end_writes();
        run_random(100);
    endtask

    // Full gain saturates every height above one half; the most negative origin
    // puts the whole X position range to its right. The spare index is dropped.
    task automatic test_saturation();
        settle();
        write_reg(REG_SIDE_X, 32'd256);
        write_reg(REG_SIDE_Z, 32'd256);
        write_reg(REG_ORG_X, 32'h8000_0000);
        write_reg(REG_ORG_Z, 32'h0000_0000);
        write_reg(REG_CPU_X, 32'h00FF_0000);
        write_reg(REG_CPU_Z, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, $urandom);
        end_writes();
        run_random(100);
    endtask

    // Zero factor pins both axes to cell 0, fraction 0, even left of the origin.
    task automatic test_zero_factor();
        settle();
        write_reg(REG_SIDE_X, 32'd2);
        write_reg(REG_SIDE_Z, 32'd2);
        write_reg(REG_ORG_X, 32'h7FFF_FFFF);
        write_reg(REG_ORG_Z, 32'h8000_0000);
        write_reg(REG_CPU_X, 32'h0000_0000);
        write_reg(REG_CPU_Z, 32'h0000_0000);
        write_reg(REG_GAIN, 32'h0001_0000);
        end_writes();
        run_random(60);
    endtask

    // Sides of 0 and 1 leave no cell; sides past the store act as the store.
    task automatic test_side_limits();
        settle();
        write_reg(REG_SIDE_X, 32'd0);
        write_reg(REG_CPU_X, 32'h0001_0000);
        write_reg(REG_CPU_Z, 32'h0001_0000);
        write_reg(REG_ORG_X, 32'h0000_0000);
        write_reg(REG_ORG_Z, 32'h0000_0000);
        end_writes();
        run_random(30);
        settle();
        write_reg(REG_SIDE_X, 32'd256);
        write_reg(REG_SIDE_Z, 32'd1);
        end_writes();
        run_random(20);
        settle();
        write_reg(REG_SIDE_X, 32'h0000_01FF);
        write_reg(REG_SIDE_Z, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, 32'd257);
        end_writes();
        run_random(50);
    endtask

    function automatic logic [31:0] random_side();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(2, 8);
            8:       return 32'd256;
            9:       return $urandom_range(0, 511);
            default: return $urandom_range(2, 256);
        endcase
    endfunction

    function automatic logic [31:0] random_origin();
        case ($urandom_range(0, 2))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] random_factor();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return $urandom;
            2:       return 32'h0001_0000;
            5:       return $urandom_range(32'h4_0000, 32'h100_0000);
            default: return $urandom_range(32'h100, 32'h4_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'd257;
            2:       return $urandom_range(0, 32'h1_0000);
            default: return $urandom_range(32'h1_0000, 32'h100_0000);
        endcase
    endfunction

    task automatic test_random_configs();
        int k;
        for (k = 0; k < 6; k++)
        begin
            settle();
            write_reg(REG_SIDE_X, random_side());
            write_reg(REG_SIDE_Z, random_side());
            write_reg(REG_ORG_X, random_origin());
            write_reg(REG_ORG_Z, random_origin());
            write_reg(REG_CPU_X, random_factor());
            write_reg(REG_CPU_Z, random_factor());
            write_reg(REG_GAIN, random_gain());
            if ($urandom_range(0, 1))
                write_reg(REG_SPARE, $urandom);
            end_writes();
            run_random(130);
        end
    endtask

    initial
    begin
        terrain_cfg.grid_side_x = SIDE_RESET;
        terrain_cfg.grid_side_z = SIDE_RESET;
        terrain_cfg.origin_x = '0;
        terrain_cfg.origin_z = '0;
        terrain_cfg.cells_per_unit_x = CPU_RESET;
        terrain_cfg.cells_per_unit_z = CPU_RESET;
        terrain_cfg.height_gain = GAIN_RESET;

        // Hold reset low, then release it away from the active edge
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed_defaults();
        test_random_defaults();
        test_small_grid();
        test_saturation();
        test_zero_factor();
        test_side_limits();
        test_random_configs();
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hq_pkg.sv
design/hq_fifo.sv
design/hq_front.sv
design/hq_back.sv
design/heightmap_height_query.sv
tb/tb_heightmap_height_query.sv
